[hdl/uvsp_pkg.sv]
// ----------------------------------------------------------------------------
// UV sphere package
// Widths, constants, register codes and the radix-2 division step shared by
// the sphere vertex generator, its sine and cosine unit and its checker.
// ----------------------------------------------------------------------------
package uvsp_pkg;

  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned INDEX_W   = 8;
  localparam int unsigned RADIUS_W  = 16;
  localparam int unsigned COORD_W   = 17;
  localparam int unsigned TRI_W     = 16;
  localparam int unsigned ANGLE_W   = 32;
  localparam int unsigned TRIG_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam int unsigned MAX_GRID_DEF        = 255;
  localparam int unsigned COORD_FRAC_BITS_DEF = 8;
  localparam int unsigned COORD_LIMIT         = 65535;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd102;
  localparam logic [COUNT_W-1:0]  SLICES_RST = 8'd10;
  localparam logic [COUNT_W-1:0]  STACKS_RST = 8'd10;

  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  localparam int unsigned NUM_TERMS = 5;
  localparam int unsigned SIN_TERMS = 4;
  localparam int unsigned SIN_DIV [NUM_TERMS] = '{6, 20, 42, 72, 2};
  localparam int unsigned COS_DIV [NUM_TERMS] = '{2, 12, 30, 56, 90};

  localparam int unsigned DIV_W      = 40;
  localparam int unsigned DIV_STAGES = 5;
  localparam int unsigned DIV_STEPS  = DIV_W / DIV_STAGES;

  localparam int unsigned LATENCY = 27;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 2'd0,
    CFG_SLICES = 2'd1,
    CFG_STACKS = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [COUNT_W-1:0] rem;
    logic [DIV_W-1:0]   nq;
  } div_t;

  function automatic div_t div_steps(div_t a, logic [COUNT_W-1:0] d);
    div_t         v;
    logic [COUNT_W:0] r2;
    v = a;
    for (int k = 0; k < DIV_STEPS; k++) begin
      r2   = {v.rem, v.nq[DIV_W-1]};
      v.nq = {v.nq[DIV_W-2:0], 1'b0};
      if (r2 >= {1'b0, d}) begin
        v.rem   = COUNT_W'(r2 - {1'b0, d});
        v.nq[0] = 1'b1;
      end else begin
        v.rem = r2[COUNT_W-1:0];
      end
    end
    return v;
  endfunction

endpackage

[hdl/uvsp_sincos.sv]
// ----------------------------------------------------------------------------
// UV sphere sine and cosine unit
// Folds a turn fraction to the first octant and evaluates truncated Taylor
// series in Q30, one term every three stages, then unfolds the result.
// ----------------------------------------------------------------------------
module uvsp_sincos
  import uvsp_pkg::*;
(
  input  logic                     clk_i,
  input  logic [ANGLE_W-1:0]       angle_i,
  output logic signed [TRIG_W-1:0] sin_o,
  output logic signed [TRIG_W-1:0] cos_o
);

  localparam int unsigned DEPTH = 2 + 3 * NUM_TERMS;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    quad_e quad;
    logic  swap;
  } fold_t;

  fold_t fold_q [DEPTH];
  logic [29:0] x_q;
  logic [29:0] rf_d;
  logic        swap_d;
  logic [29:0] x2_d;

  logic [30:0]        ts_q  [NUM_TERMS+1];
  logic [30:0]        tc_q  [NUM_TERMS+1];
  logic signed [32:0] as_q  [NUM_TERMS+1];
  logic signed [32:0] ac_q  [NUM_TERMS+1];
  logic [29:0]        x2s_q [NUM_TERMS+1];

  logic [60:0]        ps_q  [NUM_TERMS];
  logic [60:0]        pc_q  [NUM_TERMS];
  logic signed [32:0] as1_q [NUM_TERMS];
  logic signed [32:0] ac1_q [NUM_TERMS];
  logic [29:0]        x21_q [NUM_TERMS];

  logic [30:0]        vs_q  [NUM_TERMS];
  logic [30:0]        vc_q  [NUM_TERMS];
  logic [30:0]        qs_q  [NUM_TERMS];
  logic [30:0]        qc_q  [NUM_TERMS];
  logic signed [32:0] as2_q [NUM_TERMS];
  logic signed [32:0] ac2_q [NUM_TERMS];
  logic [29:0]        x22_q [NUM_TERMS];

  function automatic logic [30:0] clamp_q30(logic signed [32:0] a);
    logic [30:0] r;
    if (a < 0) begin
      r = '0;
    end else if (a > $signed({2'b00, ONE_Q30})) begin
      r = ONE_Q30;
    end else begin
      r = a[30:0];
    end
    return r;
  endfunction

  always_comb begin
    swap_d = angle_i[29:0] > 30'h2000_0000;
    rf_d   = swap_d ? 30'(ONE_Q30 - {1'b0, angle_i[29:0]}) : angle_i[29:0];
    x2_d   = 30'((60'(x_q) * 60'(x_q)) >> 30);
  end

  always_ff @(posedge clk_i) begin
    x_q       <= 30'((61'(rf_d) * 61'(HALF_PI_Q30)) >> 30);
    fold_q[0] <= '{quad: quad_e'(angle_i[31:30]), swap: swap_d};
    x2s_q[0]  <= x2_d;
    ts_q[0]   <= {1'b0, x_q};
    as_q[0]   <= $signed({3'b000, x_q});
    tc_q[0]   <= ONE_Q30;
    ac_q[0]   <= $signed({2'b00, ONE_Q30});
  end

  for (genvar n = 1; n < DEPTH; n++) begin : g_fold
    always_ff @(posedge clk_i) begin
      fold_q[n] <= fold_q[n-1];
    end
  end

  for (genvar k = 0; k < NUM_TERMS; k++) begin : g_term
    localparam logic [37:0] DS = 38'(SIN_DIV[k]);
    localparam logic [37:0] DC = 38'(COS_DIV[k]);
    localparam logic [31:0] MS = 32'((64'd1 << 32) / SIN_DIV[k]);
    localparam logic [31:0] MC = 32'((64'd1 << 32) / COS_DIV[k]);

    logic [37:0] rs_d, rc_d;
    logic [30:0] qsf_d, qcf_d;

    always_comb begin
      rs_d  = 38'(vs_q[k]) - 38'(qs_q[k]) * DS;
      rc_d  = 38'(vc_q[k]) - 38'(qc_q[k]) * DC;
      qsf_d = (rs_d >= DS) ? qs_q[k] + 31'd1 : qs_q[k];
      qcf_d = (rc_d >= DC) ? qc_q[k] + 31'd1 : qc_q[k];
    end

    always_ff @(posedge clk_i) begin
      ps_q[k]  <= 61'(ts_q[k]) * 61'(x2s_q[k]);
      pc_q[k]  <= 61'(tc_q[k]) * 61'(x2s_q[k]);
      as1_q[k] <= as_q[k];
      ac1_q[k] <= ac_q[k];
      x21_q[k] <= x2s_q[k];

      vs_q[k]  <= ps_q[k][60:30];
      vc_q[k]  <= pc_q[k][60:30];
      qs_q[k]  <= 31'((63'(ps_q[k][60:30]) * 63'(MS)) >> 32);
      qc_q[k]  <= 31'((63'(pc_q[k][60:30]) * 63'(MC)) >> 32);
      as2_q[k] <= as1_q[k];
      ac2_q[k] <= ac1_q[k];
      x22_q[k] <= x21_q[k];

      ts_q[k+1]  <= qsf_d;
      tc_q[k+1]  <= qcf_d;
      x2s_q[k+1] <= x22_q[k];
      if (k >= SIN_TERMS) begin
        as_q[k+1] <= as2_q[k];
      end else if (k % 2 == 0) begin
        as_q[k+1] <= as2_q[k] - $signed({2'b00, qsf_d});
      end else begin
        as_q[k+1] <= as2_q[k] + $signed({2'b00, qsf_d});
      end
      if (k % 2 == 0) begin
        ac_q[k+1] <= ac2_q[k] - $signed({2'b00, qcf_d});
      end else begin
        ac_q[k+1] <= ac2_q[k] + $signed({2'b00, qcf_d});
      end
    end
  end

  logic [30:0]              s_d, c_d, s0_d, c0_d;
  logic signed [TRIG_W-1:0] sn_d, cn_d;

  always_comb begin
    s_d  = clamp_q30(as_q[NUM_TERMS]);
    c_d  = clamp_q30(ac_q[NUM_TERMS]);
    s0_d = fold_q[DEPTH-1].swap ? c_d : s_d;
    c0_d = fold_q[DEPTH-1].swap ? s_d : c_d;
    sn_d = $signed({1'b0, s0_d});
    cn_d = $signed({1'b0, c0_d});
  end

  always_ff @(posedge clk_i) begin
    case (fold_q[DEPTH-1].quad)
      QUAD_0: begin
        sin_o <= sn_d;
        cos_o <= cn_d;
      end
      QUAD_1: begin
        sin_o <= cn_d;
        cos_o <= -sn_d;
      end
      QUAD_2: begin
        sin_o <= -sn_d;
        cos_o <= -cn_d;
      end
      default: begin
        sin_o <= -cn_d;
        cos_o <= sn_d;
      end
    endcase
  end

endmodule

[hdl/uv_sphere_vertex_index_generator.sv]
// ----------------------------------------------------------------------------
// UV sphere vertex and index generator
// Maps a slice and stack grid point to a point on a sphere of the configured
// radius and to the six vertex indices of the quad at that corner.
// ----------------------------------------------------------------------------
// A request is taken in every cycle in which start_i is high; busy_o stays
// low. Its result appears on the result ports 27 cycles later for one cycle
// with done_o high, in request order, and must be taken then. The latency is
// set by the five-stage angle divider and the sine and cosine series, which
// spends three stages on each of its five terms. Configuration writes are
// always ready and must only be made while no request is in flight.
module uv_sphere_vertex_index_generator
  import uvsp_pkg::*;
#(
  parameter int unsigned MAX_GRID        = MAX_GRID_DEF,
  parameter int unsigned COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [INDEX_W-1:0]         slice_index_i,
  input  logic [INDEX_W-1:0]         stack_index_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DAT_W-1:0]       cfg_data_i,
  output logic                       done_o,
  output logic signed [COORD_W-1:0]  pos_x_o,
  output logic signed [COORD_W-1:0]  pos_y_o,
  output logic signed [COORD_W-1:0]  pos_z_o,
  output logic [TRI_W-1:0]           tri_first_a_o,
  output logic [TRI_W-1:0]           tri_first_b_o,
  output logic [TRI_W-1:0]           tri_first_c_o,
  output logic [TRI_W-1:0]           tri_second_a_o,
  output logic [TRI_W-1:0]           tri_second_b_o,
  output logic [TRI_W-1:0]           tri_second_c_o,
  output logic                       triangles_valid_o,
  output logic                       index_error_o
);

  localparam int unsigned        SHIFT    = 38 - COORD_FRAC_BITS;
  localparam logic [47:0]        ROUND    = 48'd1 << (SHIFT - 1);
  localparam logic [COUNT_W-1:0] GRID_MAX = COUNT_W'(MAX_GRID);

  typedef struct packed {
    logic             err;
    logic             tv;
    logic [TRI_W-1:0] p0;
    logic [TRI_W-1:0] p1;
  } side_t;

  logic [RADIUS_W-1:0] radius_q;
  logic [COUNT_W-1:0]  slices_q, stacks_q, sl, st;

  logic               vld_q  [LATENCY-1];
  side_t              side_q [LATENCY-2];
  logic [INDEX_W-1:0] i_q, j_q;
  div_t               dt_q [DIV_STAGES];
  div_t               dp_q [DIV_STAGES];
  div_t               th_init, ph_init;
  side_t              side_d;
  logic [8:0]         w_d;
  logic [16:0]        p0_d;

  logic [ANGLE_W-1:0]       ang_th, ang_ph;
  logic signed [TRIG_W-1:0] sth, cth, sph, cph;

  logic [30:0] msph, mcth, msth, mcph;
  logic [30:0] fxm_q, fym_q, fzm_q;
  logic        fxn_q, fyn_q, fzn_q;
  logic [46:0] px_q, py_q, pz_q;
  logic        nx_q, ny_q, nz_q;

  logic                      done_q;
  logic signed [COORD_W-1:0] pos_x_q, pos_y_q, pos_z_q;
  side_t                     out_q;

  function automatic logic signed [COORD_W-1:0] coord(logic [46:0] p, logic neg);
    logic [47:0] v;
    logic [15:0] sat;
    v   = (48'(p) + ROUND) >> SHIFT;
    sat = (v > 48'(COORD_LIMIT)) ? 16'(COORD_LIMIT) : v[15:0];
    return neg ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
  endfunction

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      slices_q <= SLICES_RST;
      stacks_q <= STACKS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_RADIUS: radius_q <= cfg_data_i;
        CFG_SLICES: slices_q <= cfg_data_i[COUNT_W-1:0];
        CFG_STACKS: stacks_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign sl = (slices_q > GRID_MAX) ? GRID_MAX : slices_q;
  assign st = (stacks_q > GRID_MAX) ? GRID_MAX : stacks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= start_i;
    end
  end

  for (genvar n = 1; n < LATENCY - 1; n++) begin : g_vld
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[n] <= 1'b0;
      end else begin
        vld_q[n] <= vld_q[n-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= slice_index_i;
    j_q <= stack_index_i;
  end

  always_comb begin
    w_d       = {1'b0, st} + 9'd1;
    p0_d      = 17'(i_q) * 17'(w_d) + 17'(j_q);
    side_d.err = (i_q > sl) || (j_q > st);
    side_d.tv  = (i_q < sl) && (j_q < st);
    side_d.p0  = p0_d[TRI_W-1:0];
    side_d.p1  = 16'(p0_d + 17'(w_d));
    th_init.rem = '0;
    th_init.nq  = {i_q, 32'd0} + {33'd0, sl[COUNT_W-1:1]};
    ph_init.rem = '0;
    ph_init.nq  = {1'b0, j_q, 31'd0} + {33'd0, st[COUNT_W-1:1]};
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
  end

  for (genvar n = 1; n < LATENCY - 2; n++) begin : g_side
    always_ff @(posedge clk_i) begin
      side_q[n] <= side_q[n-1];
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    if (s == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        dt_q[s] <= div_steps(th_init, sl);
        dp_q[s] <= div_steps(ph_init, st);
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        dt_q[s] <= div_steps(dt_q[s-1], sl);
        dp_q[s] <= div_steps(dp_q[s-1], st);
      end
    end
  end

  assign ang_th = (sl == '0) ? '0 : dt_q[DIV_STAGES-1].nq[ANGLE_W-1:0];
  assign ang_ph = (st == '0) ? '0 : dp_q[DIV_STAGES-1].nq[ANGLE_W-1:0];

  uvsp_sincos u_theta (
    .clk_i   (clk_i),
    .angle_i (ang_th),
    .sin_o   (sth),
    .cos_o   (cth)
  );

  uvsp_sincos u_phi (
    .clk_i   (clk_i),
    .angle_i (ang_ph),
    .sin_o   (sph),
    .cos_o   (cph)
  );

  always_comb begin
    msph = 31'(sph[TRIG_W-1] ? -sph : sph);
    mcth = 31'(cth[TRIG_W-1] ? -cth : cth);
    msth = 31'(sth[TRIG_W-1] ? -sth : sth);
    mcph = 31'(cph[TRIG_W-1] ? -cph : cph);
  end

  always_ff @(posedge clk_i) begin
    fxm_q <= 31'((62'(msph) * 62'(mcth) + (62'd1 << 29)) >> 30);
    fym_q <= 31'((62'(msph) * 62'(msth) + (62'd1 << 29)) >> 30);
    fzm_q <= mcph;
    fxn_q <= sph[TRIG_W-1] ^ cth[TRIG_W-1];
    fyn_q <= sph[TRIG_W-1] ^ sth[TRIG_W-1];
    fzn_q <= cph[TRIG_W-1];

    px_q <= 47'(fxm_q) * 47'(radius_q);
    py_q <= 47'(fym_q) * 47'(radius_q);
    pz_q <= 47'(fzm_q) * 47'(radius_q);
    nx_q <= fxn_q;
    ny_q <= fyn_q;
    nz_q <= fzn_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[LATENCY-2];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= side_q[LATENCY-3];
    if (side_q[LATENCY-3].err) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
    end else begin
      pos_x_q <= coord(px_q, nx_q);
      pos_y_q <= coord(py_q, ny_q);
      pos_z_q <= coord(pz_q, nz_q);
    end
  end

  assign done_o            = done_q;
  assign pos_x_o           = pos_x_q;
  assign pos_y_o           = pos_y_q;
  assign pos_z_o           = pos_z_q;
  assign triangles_valid_o = out_q.tv;
  assign index_error_o     = out_q.err;
  assign tri_first_a_o     = out_q.tv ? out_q.p0 : '0;
  assign tri_first_b_o     = out_q.tv ? out_q.p1 : '0;
  assign tri_first_c_o     = out_q.tv ? out_q.p1 + 16'd1 : '0;
  assign tri_second_a_o    = out_q.tv ? out_q.p0 : '0;
  assign tri_second_b_o    = out_q.tv ? out_q.p1 + 16'd1 : '0;
  assign tri_second_c_o    = out_q.tv ? out_q.p0 + 16'd1 : '0;

endmodule

[hdl/uvsp_checker.sv]
// ----------------------------------------------------------------------------
// UV sphere checker
// Port-level checks of request timing and result consistency.
// ----------------------------------------------------------------------------
module uvsp_checker
  import uvsp_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input logic                      done_o,
  input logic signed [COORD_W-1:0] pos_x_o,
  input logic signed [COORD_W-1:0] pos_y_o,
  input logic signed [COORD_W-1:0] pos_z_o,
  input logic [TRI_W-1:0]          tri_first_a_o,
  input logic [TRI_W-1:0]          tri_first_c_o,
  input logic [TRI_W-1:0]          tri_second_a_o,
  input logic [TRI_W-1:0]          tri_second_b_o,
  input logic                      triangles_valid_o,
  input logic                      index_error_o
);

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LATENCY done_o)
    else $error("accepted request produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without a matching request");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && index_error_o |-> !triangles_valid_o && pos_x_o == 0
      && pos_y_o == 0 && pos_z_o == 0)
    else $error("error result carries data");

  a_shared_corners: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && triangles_valid_o |-> tri_first_a_o == tri_second_a_o
      && tri_first_c_o == tri_second_b_o)
    else $error("triangles do not share their diagonal");

endmodule

bind uv_sphere_vertex_index_generator uvsp_checker u_uvsp_checker (.*);

[dv/uv_sphere_vertex_index_generator_test.sv]
// ----------------------------------------------------------------------------
// UV sphere vertex generator test
// Drives grid points under several radius and grid settings, predicts each
// sphere point and its quad indices in fixed point, and compares every result.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_index_generator_test
  import uvsp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [COORD_W-1:0] x, y, z;
    logic [TRI_W-1:0] fa, fb, fc, sa, sb, sc;
    logic tv, err;
  } vertex_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [INDEX_W-1:0] slice_index_i = '0;
  logic [INDEX_W-1:0] stack_index_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  logic done_o;
  logic signed [COORD_W-1:0] pos_x_o, pos_y_o, pos_z_o;
  logic [TRI_W-1:0] tri_first_a_o, tri_first_b_o, tri_first_c_o;
  logic [TRI_W-1:0] tri_second_a_o, tri_second_b_o, tri_second_c_o;
  logic triangles_valid_o, index_error_o;

  uv_sphere_vertex_index_generator u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  longint unsigned radius_q = RADIUS_RST;
  longint unsigned slices_q = SLICES_RST;
  longint unsigned stacks_q = STACKS_RST;
  vertex_t expected_vertices[$];
  int errors = 0;
  int points_sent = 0;
  int vertices_seen = 0;
  int idle_cycles = 0;

  task automatic taylor(input longint unsigned x, output longint s, output longint c);
    longint unsigned x2, t;
    longint a;
    x2 = (x * x) >> 30;
    t = x;
    a = x;
    for (int k = 1; k <= 4; k++) begin
      t = ((t * x2) >> 30) / ((2 * k) * (2 * k + 1));
      a = (k & 1) ? a - longint'(t) : a + longint'(t);
    end
    s = (a < 0) ? 0 : (a > (64'd1 << 30)) ? (64'd1 << 30) : a;
    t = 64'd1 << 30;
    a = 64'd1 << 30;
    for (int k = 1; k <= 5; k++) begin
      t = ((t * x2) >> 30) / ((2 * k - 1) * (2 * k));
      a = (k & 1) ? a - longint'(t) : a + longint'(t);
    end
    c = (a < 0) ? 0 : (a > (64'd1 << 30)) ? (64'd1 << 30) : a;
  endtask

  task automatic turn_sincos(input logic [31:0] ang, output longint s, output longint c);
    longint unsigned r;
    longint s0, c0, t;
    r = 64'(ang[29:0]);
    if (r > (64'd1 << 29)) taylor(((64'd1 << 30) - r) * HALF_PI_Q30 >> 30, c0, s0);
    else taylor((r * HALF_PI_Q30) >> 30, s0, c0);
    case (ang[31:30])
      2'd0: ;
      2'd1: begin t = s0; s0 = c0; c0 = -t; end
      2'd2: begin s0 = -s0; c0 = -c0; end
      default: begin t = s0; s0 = -c0; c0 = t; end
    endcase
    s = s0;
    c = c0;
  endtask

  function automatic longint round_product(longint a, longint b, int sh);
    longint unsigned ma, mb, q;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    q = (ma * mb + (64'd1 << (sh - 1))) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [COORD_W-1:0] scale_coord(longint f);
    longint v;
    v = round_product(f, radius_q, 38 - COORD_FRAC_BITS_DEF);
    if (v > longint'(COORD_LIMIT)) v = longint'(COORD_LIMIT);
    if (v < -longint'(COORD_LIMIT)) v = -longint'(COORD_LIMIT);
    return v[COORD_W-1:0];
  endfunction

  task automatic predict_vertex(input longint unsigned i, input longint unsigned j,
                                output vertex_t v);
    longint unsigned sl, st, w, p0, p1;
    logic [31:0] ath, aph;
    longint sth, cth, sph, cph;
    v = '0;
    sl = slices_q;
    st = stacks_q;
    ath = '0;
    aph = '0;
    if (i > sl || j > st) begin
      v.err = 1'b1;
      return;
    end
    if (sl != 0) ath = 32'(((i << 32) + sl / 2) / sl);
    if (st != 0) aph = 32'(((j << 31) + st / 2) / st);
    turn_sincos(ath, sth, cth);
    turn_sincos(aph, sph, cph);
    v.x = scale_coord(round_product(sph, cth, 30));
    v.y = scale_coord(round_product(sph, sth, 30));
    v.z = scale_coord(cph);
    if (i < sl && j < st) begin
      w = st + 1;
      p0 = i * w + j;
      p1 = (i + 1) * w + j;
      v.fa = p0[15:0];
      v.fb = p1[15:0];
      v.fc = 16'(p1 + 1);
      v.sa = p0[15:0];
      v.sb = 16'(p1 + 1);
      v.sc = 16'(p0 + 1);
      v.tv = 1'b1;
    end
  endtask

  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 1 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 40);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_point(input logic [7:0] i, input logic [7:0] j, input bit gaps);
    vertex_t v;
    predict_vertex(i, j, v);
    start_i <= 1'b1;
    slice_index_i <= i;
    stack_index_i <= j;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_vertices = {expected_vertices, v};
    points_sent++;
    if (gaps && $urandom_range(0, 2) == 0) begin
      start_i <= 1'b0;
      random_gap();
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_RADIUS: radius_q = data;
      CFG_SLICES: slices_q = data[7:0];
      default: stacks_q = data[7:0];
    endcase
  endtask

  task automatic set_grid(input logic [15:0] r, input logic [7:0] sl, input logic [7:0] st);
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_SLICES, 16'(sl));
    write_reg(CFG_STACKS, 16'(st));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed();
    send_point(0, 0, 0);
    send_point(10, 10, 0);
    send_point(5, 5, 0);
    send_point(11, 0, 0);
    send_point(0, 11, 0);
    send_point(255, 255, 0);
    drain();
    set_grid(16'hFFFF, 8'd255, 8'd255);
    send_point(0, 0, 0);
    send_point(254, 254, 0);
    send_point(255, 255, 0);
    send_point(64, 128, 0);
    send_point(191, 77, 0);
    drain();
    set_grid(16'd0, 8'd1, 8'd1);
    send_point(0, 0, 0);
    send_point(1, 1, 0);
    send_point(2, 0, 0);
    drain();
    set_grid(16'd300, 8'd0, 8'd0);
    send_point(0, 0, 0);
    send_point(1, 0, 0);
    send_point(0, 1, 0);
    drain();
  endtask

  task automatic test_random(input int n);
    logic [7:0] i, j;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 8) begin
        i = 8'($urandom_range(0, 32'(slices_q)));
        j = 8'($urandom_range(0, 32'(stacks_q)));
      end else begin
        i = 8'($urandom);
        j = 8'($urandom);
      end
      send_point(i, j, 1);
    end
    drain();
  endtask

  task automatic test_settings();
    set_grid(16'($urandom), 8'd16, 8'd8); test_random(200);
    set_grid(16'hFFFF, 8'd255, 8'd255); test_random(200);
    set_grid(16'($urandom_range(1, 2000)), 8'd3, 8'd200); test_random(200);
    set_grid(16'($urandom), 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
    test_random(200);
    set_grid(16'd1, 8'd255, 8'd1); test_random(150);
    set_grid(16'($urandom), 8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)));
    test_random(180);
  endtask

  always @(posedge clk_i) begin
    vertex_t got, exp_v;
    if (rst_ni && done_o) begin
      got = '{pos_x_o, pos_y_o, pos_z_o, tri_first_a_o, tri_first_b_o, tri_first_c_o,
              tri_second_a_o, tri_second_b_o, tri_second_c_o,
              triangles_valid_o, index_error_o};
      vertices_seen++;
      if (expected_vertices.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p", $time, got);
      end else begin
        exp_v = expected_vertices.pop_front();
        if (got.x !== exp_v.x) $display("%0t: pos_x exp %0d got %0d", $time, exp_v.x, got.x);
        if (got.y !== exp_v.y) $display("%0t: pos_y exp %0d got %0d", $time, exp_v.y, got.y);
        if (got.z !== exp_v.z) $display("%0t: pos_z exp %0d got %0d", $time, exp_v.z, got.z);
        if (got !== exp_v) begin
          errors++;
          $display("%0t: result mismatch exp %p got %p", $time, exp_v, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || cfg_valid_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_settings();
    if (expected_vertices.size() != 0) begin
      errors++;
      $display("%0t: %0d results missing", $time, expected_vertices.size());
    end
    $display("Sent %0d grid points across ten grid settings, checked %0d vertices.",
             points_sent, vertices_seen);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
